[hdl/ide_pkg.sv]
// ----------------------------------------------------------------------------
// ide_pkg
// Shared widths, types and codes of the interval diff encoder.
// ----------------------------------------------------------------------------
package ide_pkg;

   localparam int unsigned MAX_WINDOW = 56;
   localparam int unsigned HELD_DEPTH = 60;
   localparam int unsigned HELD_AW    = $clog2(HELD_DEPTH);

   localparam int unsigned WORD_W     = 32;
   localparam int unsigned HALF_W     = 64;
   localparam int unsigned WIN_W      = 6;
   localparam int unsigned BLK_W      = 30;
   localparam int unsigned KIND_W     = 2;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 30;

   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [HALF_W-1:0]  half_type;
   typedef logic [WIN_W-1:0]   win_type;
   typedef logic [BLK_W-1:0]   blk_type;
   typedef logic [KIND_W-1:0]  kind_type;
   typedef logic [HELD_AW-1:0] cnt_type;

   // result kinds
   localparam kind_type KIND_START = 2'd0;
   localparam kind_type KIND_DATA  = 2'd1;
   localparam kind_type KIND_END   = 2'd2;
   localparam kind_type KIND_TOTAL = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_START  = 1'b1;

   localparam win_type WINDOW_RESET = 6'd32;
   localparam win_type WINDOW_MAX   = WIN_W'(MAX_WINDOW);

endpackage

[hdl/interval_diff_encoder.sv]
// ----------------------------------------------------------------------------
// interval_diff_encoder
// Run-length diff stream of changed 32-bit words over an interval of blocks.
// ----------------------------------------------------------------------------
// the result words of an item leave through the output register; held words of a
//   run are read from the RAM first when a change flushes them
// throughput: at most one result per cycle, held while the receiver stalls; a
//   block in a run goes word by word, a run start, a run end and the total add a
//   word each, and an unchanged block outside a run emits no word
// reset: synchronous; clears run, counters and handshakes, window 32, start 0
module interval_diff_encoder (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ide_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ide_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  ide_pkg::half_type                  req_new_low,
   input  ide_pkg::half_type                  req_new_high,
   input  ide_pkg::half_type                  req_old_low,
   input  ide_pkg::half_type                  req_old_high,
   input  logic                               req_final_block,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output ide_pkg::kind_type                  rsp_word_kind,
   output ide_pkg::word_type                  rsp_word_value,
   output logic                               rsp_item_last
);

   localparam logic [2:0] S_DECIDE = 3'd0;
   localparam logic [2:0] S_FLUSH  = 3'd1;
   localparam logic [2:0] S_WORDS  = 3'd2;
   localparam logic [2:0] S_END    = 3'd3;
   localparam logic [2:0] S_TOTAL  = 3'd4;

   // input item register
   logic                 in_valid_ff, in_valid_in;
   ide_pkg::half_type    in_low_ff, in_high_ff;
   logic                 lo_ch_ff, hi_ch_ff, in_final_ff;

   // engine state
   logic [2:0]           state_ff, state_in;
   logic [1:0]           widx_ff, widx_in;
   logic                 open_blk_ff, open_blk_in;
   ide_pkg::cnt_type     rd_cnt_ff, rd_cnt_in;
   logic                 pend_ff, pend_in;
   logic                 run_open_ff, run_open_in;
   ide_pkg::cnt_type     tc_ff, tc_in;
   ide_pkg::word_type    total_ff, total_in;
   ide_pkg::blk_type     blk_ff, blk_in;
   ide_pkg::win_type     window_ff, window_in;
   ide_pkg::blk_type     start_ff, start_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   ide_pkg::kind_type    rsp_kind_ff;
   ide_pkg::word_type    rsp_value_ff;
   logic                 rsp_last_ff;

   logic                 out_load;
   ide_pkg::kind_type    out_kind;
   ide_pkg::word_type    out_value;
   logic                 out_last;

   logic                 ram_wr_en, ram_rd_en;
   ide_pkg::word_type    ram_rd_data;

   logic                 out_can_load, chg, in_words, opening, emit_word, advance;
   logic                 close, last_pos, word_last, item_done, req_accept;
   logic                 emit_ok, issue;
   logic [1:0]           k;
   ide_pkg::cnt_type     tc_step, win;
   ide_pkg::word_type    pos4, cur_word;

   ide_ram #(
      .WIDTH (ide_pkg::WORD_W),
      .DEPTH (ide_pkg::HELD_DEPTH)
   ) u_held (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tc_ff),
      .wr_data (cur_word),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_cnt_ff),
      .rd_data (ram_rd_data)
   );

   assign csr_ready    = 1'b1;
   assign out_can_load = !rsp_valid_ff || rsp_ready;
   assign chg          = lo_ch_ff || hi_ch_ff;
   assign win          = ide_pkg::cnt_type'((window_ff > ide_pkg::WINDOW_MAX) ?
                                            ide_pkg::WINDOW_MAX : window_ff);
   assign pos4         = {blk_ff, 2'b00};

   // a block inside a run with nothing to flush starts its words right away
   assign in_words = (state_ff == S_WORDS) ||
                     ((state_ff == S_DECIDE) && in_valid_ff && run_open_ff &&
                      !(chg && (tc_ff != '0)));
   assign k        = (state_ff == S_WORDS) ? widx_ff : 2'd0;
   assign opening  = (state_ff == S_WORDS) && open_blk_ff;
   assign emit_word = opening || hi_ch_ff || (lo_ch_ff && !k[1]);
   assign tc_step  = emit_word ? tc_ff : tc_ff + 1'b1;
   assign close    = (tc_step > win) || in_final_ff;

   // last word of the item unless a run end follows
   assign last_pos  = (opening || hi_ch_ff) ? (k == 2'd3) : (k == 2'd1);
   assign word_last = last_pos && !in_final_ff &&
                      !(!opening && !hi_ch_ff && (win < 2));

   always_comb begin
      case (k)
         2'd0:    cur_word = in_low_ff[31:0];
         2'd1:    cur_word = in_low_ff[63:32];
         2'd2:    cur_word = in_high_ff[31:0];
         2'd3:    cur_word = in_high_ff[63:32];
         default: cur_word = in_low_ff[31:0];
      endcase
   end

   assign req_ready  = !in_valid_ff || item_done;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      state_in    = state_ff;
      widx_in     = widx_ff;
      open_blk_in = open_blk_ff;
      rd_cnt_in   = rd_cnt_ff;
      pend_in     = pend_ff;
      run_open_in = run_open_ff;
      tc_in       = tc_ff;
      total_in    = total_ff;
      blk_in      = blk_ff;
      window_in   = window_ff;
      start_in    = start_ff;
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      out_load    = 1'b0;
      out_kind    = ide_pkg::KIND_DATA;
      out_value   = cur_word;
      out_last    = 1'b0;
      item_done   = 1'b0;
      advance     = 1'b0;
      emit_ok     = 1'b0;
      issue       = 1'b0;

      if (in_words) begin
         if (emit_word) begin
            if (out_can_load) begin
               out_load = 1'b1;
               out_last = word_last;
               total_in = total_ff + 32'd1;
               advance  = 1'b1;
            end
         end else begin
            ram_wr_en = 1'b1;
            tc_in     = tc_step;
            advance   = 1'b1;
         end
         if (advance) begin
            if (k == 2'd3) begin
               open_blk_in = 1'b0;
               if (close) begin
                  state_in = S_END;
               end else begin
                  item_done = 1'b1;
                  blk_in    = blk_ff + 1'b1;
                  state_in  = S_DECIDE;
               end
            end else begin
               widx_in  = k + 2'd1;
               state_in = S_WORDS;
            end
         end
      end else begin
         case (state_ff)
            S_DECIDE: begin
               if (in_valid_ff) begin
                  if (!run_open_ff) begin
                     if (chg) begin
                        if (out_can_load) begin
                           out_load    = 1'b1;
                           out_kind    = ide_pkg::KIND_START;
                           out_value   = pos4 + (lo_ch_ff ? 32'd0 : 32'd2);
                           total_in    = total_ff + 32'd2;
                           run_open_in = 1'b1;
                           tc_in       = '0;
                           widx_in     = lo_ch_ff ? 2'd0 : 2'd2;
                           open_blk_in = 1'b1;
                           state_in    = S_WORDS;
                        end
                     end else if (in_final_ff) begin
                        state_in = S_TOTAL;
                     end else begin
                        item_done = 1'b1;
                        blk_in    = blk_ff + 1'b1;
                     end
                  end else begin
                     // change inside a run: held words go out first
                     rd_cnt_in = '0;
                     pend_in   = 1'b0;
                     state_in  = S_FLUSH;
                  end
               end
            end
            S_FLUSH: begin
               emit_ok = pend_ff && out_can_load;
               if (emit_ok) begin
                  out_load  = 1'b1;
                  out_value = ram_rd_data;
                  total_in  = total_ff + 32'd1;
               end
               issue = (rd_cnt_ff != tc_ff) && (!pend_ff || out_can_load);
               if (issue) begin
                  ram_rd_en = 1'b1;
                  rd_cnt_in = rd_cnt_ff + 1'b1;
               end
               pend_in = issue || (pend_ff && !emit_ok);
               if ((rd_cnt_ff == tc_ff) && (!pend_ff || emit_ok)) begin
                  tc_in    = '0;
                  widx_in  = 2'd0;
                  state_in = S_WORDS;
               end
            end
            S_END: begin
               if (out_can_load) begin
                  out_load    = 1'b1;
                  out_kind    = ide_pkg::KIND_END;
                  out_value   = pos4 + 32'd4 - 32'(tc_ff);
                  out_last    = !in_final_ff;
                  run_open_in = 1'b0;
                  tc_in       = '0;
                  if (in_final_ff) begin
                     state_in = S_TOTAL;
                  end else begin
                     item_done = 1'b1;
                     blk_in    = blk_ff + 1'b1;
                     state_in  = S_DECIDE;
                  end
               end
            end
            S_TOTAL: begin
               if (out_can_load) begin
                  out_load    = 1'b1;
                  out_kind    = ide_pkg::KIND_TOTAL;
                  out_value   = total_ff;
                  out_last    = 1'b1;
                  run_open_in = 1'b0;
                  tc_in       = '0;
                  total_in    = '0;
                  blk_in      = start_ff;
                  item_done   = 1'b1;
                  state_in    = S_DECIDE;
               end
            end
            default: begin
               state_in = S_DECIDE;
            end
         endcase
      end

      // register writes must only come while idle; the block itself does not enforce it
      if (csr_valid && csr_ready) begin
         case (csr_index)
            ide_pkg::CSR_WINDOW: begin
               window_in = csr_wdata[ide_pkg::WIN_W-1:0];
            end
            ide_pkg::CSR_START: begin
               start_in = csr_wdata[ide_pkg::BLK_W-1:0];
               blk_in   = csr_wdata[ide_pkg::BLK_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign in_valid_in  = req_accept || (in_valid_ff && !item_done);
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= S_DECIDE;
         widx_ff      <= 2'd0;
         open_blk_ff  <= 1'b0;
         rd_cnt_ff    <= '0;
         pend_ff      <= 1'b0;
         run_open_ff  <= 1'b0;
         tc_ff        <= '0;
         total_ff     <= '0;
         blk_ff       <= '0;
         window_ff    <= ide_pkg::WINDOW_RESET;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         widx_ff      <= widx_in;
         open_blk_ff  <= open_blk_in;
         rd_cnt_ff    <= rd_cnt_in;
         pend_ff      <= pend_in;
         run_open_ff  <= run_open_in;
         tc_ff        <= tc_in;
         total_ff     <= total_in;
         blk_ff       <= blk_in;
         window_ff    <= window_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_low_ff   <= req_new_low;
         in_high_ff  <= req_new_high;
         lo_ch_ff    <= req_new_low != req_old_low;
         hi_ch_ff    <= req_new_high != req_old_high;
         in_final_ff <= req_final_block;
      end
      if (out_load) begin
         rsp_kind_ff  <= out_kind;
         rsp_value_ff <= out_value;
         rsp_last_ff  <= out_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_word_kind  = rsp_kind_ff;
   assign rsp_word_value = rsp_value_ff;
   assign rsp_item_last  = rsp_last_ff;

endmodule

[hdl/ide_ram.sv]
// ----------------------------------------------------------------------------
// ide_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ide_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 60
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[verif/interval_diff_encoder_tb.sv]
// ----------------------------------------------------------------------------
// interval_diff_encoder_tb
// Self-checking bench for the interval diff encoder. A directed table covers
// the corner cases, then random intervals run under several window and start
// settings and handshake timings. The bench checks every result word, field
// by field, against an in-bench predictor or a directed row's listed words.
// ----------------------------------------------------------------------------
module interval_diff_encoder_tb;

   localparam int SETTLE_CYCLES  = 10;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int N_PHASES       = 7;
   localparam int PHASE_BLOCKS   = 42;

   localparam ide_pkg::half_type HALF_A = 64'h0123_4567_89AB_CDEF;
   localparam ide_pkg::half_type HALF_B = 64'hFEDC_BA98_7654_3210;

   localparam logic [ide_pkg::CSR_DATA_W-1:0] PHASE_WIN [N_PHASES] =
      '{30'd32, 30'd0, 30'd56, 30'd63, 30'h3FFF_FFC4, 30'd1, 30'd17};
   localparam logic [ide_pkg::CSR_DATA_W-1:0] PHASE_START [N_PHASES] =
      '{30'd0, 30'd7, 30'h3FFF_FFFF, 30'h2AAA_AAAA, 30'h1555_5555, 30'h3FFF_FFFE, 30'd0};
   // sender idle and receiver stall, percent per cycle
   localparam int IDLE_PCT  [4] = '{0, 85, 0, 14};
   localparam int STALL_PCT [4] = '{0, 0, 85, 14};

   typedef enum logic [1:0] {ROW_BLOCK, ROW_WINDOW, ROW_START} row_op_type;

   typedef struct packed {
      row_op_type                 op;
      ide_pkg::half_type          nl;
      ide_pkg::half_type          nh;
      ide_pkg::half_type          ol;
      ide_pkg::half_type          oh;
      logic                       fin;
      logic                       typed;
      logic [1:0]                 n_typed;
      ide_pkg::kind_type [2:0]    t_kind;
      ide_pkg::word_type [2:0]    t_val;
   } blk_row_type;

   typedef struct packed {
      ide_pkg::kind_type kind;
      ide_pkg::word_type value;
      logic              last;
   } rsp_rec_type;

   logic                           clock           = 1'b0;
   logic                           reset           = 1'b1;
   logic                           csr_valid       = 1'b0;
   logic                           csr_ready;
   logic [ide_pkg::CSR_IDX_W-1:0]  csr_index       = '0;
   logic [ide_pkg::CSR_DATA_W-1:0] csr_wdata       = '0;
   logic                           req_valid       = 1'b0;
   logic                           req_ready;
   ide_pkg::half_type              req_new_low     = '0;
   ide_pkg::half_type              req_new_high    = '0;
   ide_pkg::half_type              req_old_low     = '0;
   ide_pkg::half_type              req_old_high    = '0;
   logic                           req_final_block = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready       = 1'b0;
   ide_pkg::kind_type              rsp_word_kind;
   ide_pkg::word_type              rsp_word_value;
   logic                           rsp_item_last;

   // predictor state and register mirror
   ide_pkg::win_type  m_window   = ide_pkg::WINDOW_RESET;
   ide_pkg::blk_type  m_start    = '0;
   ide_pkg::blk_type  m_block    = '0;
   logic              m_run_open = 1'b0;
   int unsigned       m_trailing = 0;
   ide_pkg::word_type m_held [ide_pkg::HELD_DEPTH];
   ide_pkg::word_type m_total    = '0;

   rsp_rec_type pending_words [$];
   rsp_rec_type head;
   int          idle_pct     = 0;
   int          stall_pct    = 0;
   int          n_fail       = 0;
   int          n_blocks     = 0;
   int          n_words      = 0;
   int          n_runs       = 0;
   int          n_intervals  = 0;
   int          quiet_cycles = 0;

   interval_diff_encoder i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_new_low     (req_new_low),
      .req_new_high    (req_new_high),
      .req_old_low     (req_old_low),
      .req_old_high    (req_old_high),
      .req_final_block (req_final_block),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_word_kind   (rsp_word_kind),
      .rsp_word_value  (rsp_word_value),
      .rsp_item_last   (rsp_item_last)
   );

   always #10 clock = ~clock;

   function automatic void put(ref rsp_rec_type res[$], input ide_pkg::kind_type kind,
                               input ide_pkg::word_type value);
      res.push_back('{kind, value, 1'b0});
   endfunction

   function automatic void put_data(ref rsp_rec_type res[$], input ide_pkg::word_type value);
      put(res, ide_pkg::KIND_DATA, value);
      m_total = m_total + 1;
   endfunction

   // advances the predictor by one block and returns the words it causes
   function automatic void encode_block(input ide_pkg::half_type nl,
                                        input ide_pkg::half_type nh,
                                        input ide_pkg::half_type ol,
                                        input ide_pkg::half_type oh,
                                        input logic fin, ref rsp_rec_type res[$]);
      logic              lo_ch;
      logic              hi_ch;
      ide_pkg::word_type w [4];
      int unsigned       win;
      int unsigned       first;
      int unsigned       keep;
      ide_pkg::word_type pos4;
      lo_ch = (nl != ol);
      hi_ch = (nh != oh);
      w[0]  = nl[31:0];
      w[1]  = nl[63:32];
      w[2]  = nh[31:0];
      w[3]  = nh[63:32];
      win   = (m_window > ide_pkg::WINDOW_MAX) ? ide_pkg::MAX_WINDOW : m_window;
      pos4  = {m_block, 2'b00};
      res.delete();
      if (!m_run_open) begin
         if (lo_ch || hi_ch) begin
            first = lo_ch ? 0 : 2;
            put(res, ide_pkg::KIND_START, pos4 + first);
            m_total = m_total + 2;
            for (int k = first; k < 4; k++) put_data(res, w[k]);
            m_trailing = 0;
            m_run_open = 1'b1;
            if (fin) begin
               put(res, ide_pkg::KIND_END, pos4 + 4);
               m_run_open = 1'b0;
            end
         end
      end else begin
         // words of this block that go out now; the rest are held
         keep = hi_ch ? 4 : (lo_ch ? 2 : 0);
         if (lo_ch || hi_ch) begin
            for (int k = 0; k < m_trailing && k < ide_pkg::HELD_DEPTH; k++)
               put_data(res, m_held[k]);
            m_trailing = 0;
         end
         for (int k = 0; k < keep; k++) put_data(res, w[k]);
         for (int k = keep; k < 4; k++) begin
            if (m_trailing < ide_pkg::HELD_DEPTH) m_held[m_trailing] = w[k];
            m_trailing++;
         end
         if (m_trailing > win || fin) begin
            put(res, ide_pkg::KIND_END, pos4 + 4 - m_trailing);
            m_run_open = 1'b0;
            m_trailing = 0;
         end
      end
      m_block = m_block + 1'b1;
      if (fin) begin
         put(res, ide_pkg::KIND_TOTAL, m_total);
         m_run_open = 1'b0;
         m_trailing = 0;
         m_total    = '0;
         m_block    = m_start;
      end
      if (res.size() > 0) res[res.size()-1].last = 1'b1;
   endfunction

   function automatic blk_row_type blk(input ide_pkg::half_type nl, input ide_pkg::half_type nh,
                                       input ide_pkg::half_type ol, input ide_pkg::half_type oh,
                                       input logic fin);
      blk_row_type r;
      r     = '0;
      r.op  = ROW_BLOCK;
      r.nl  = nl;
      r.nh  = nh;
      r.ol  = ol;
      r.oh  = oh;
      r.fin = fin;
      return r;
   endfunction

   // results listed first to last in k and v
   function automatic blk_row_type blk_typed(input ide_pkg::half_type nl,
                                             input ide_pkg::half_type nh,
                                             input ide_pkg::half_type ol,
                                             input ide_pkg::half_type oh,
                                             input logic fin, input int n,
                                             input ide_pkg::kind_type [2:0] k,
                                             input ide_pkg::word_type [2:0] v);
      blk_row_type r;
      r         = blk(nl, nh, ol, oh, fin);
      r.typed   = 1'b1;
      r.n_typed = n[1:0];
      r.t_kind  = k;
      r.t_val   = v;
      return r;
   endfunction

   function automatic blk_row_type cfg_row(input row_op_type op,
                                           input logic [ide_pkg::CSR_DATA_W-1:0] data);
      blk_row_type r;
      r    = '0;
      r.op = op;
      r.nl = ide_pkg::half_type'(data);
      return r;
   endfunction

   function automatic ide_pkg::half_type rand_half();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic ide_pkg::half_type flip_half(input ide_pkg::half_type x);
      if ($urandom_range(1)) return x ^ (64'd1 << $urandom_range(63));
      return rand_half();
   endfunction

   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [ide_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ide_pkg::CSR_DATA_W-1:0] data);
      wait_idle();
      // a block that caused no words may still be busy
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == ide_pkg::CSR_WINDOW) begin
         m_window = data[ide_pkg::WIN_W-1:0];
      end else begin
         m_start = data[ide_pkg::BLK_W-1:0];
         m_block = data[ide_pkg::BLK_W-1:0];
      end
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_block(input blk_row_type r);
      rsp_rec_type got [$];
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_new_low     = r.nl;
      req_new_high    = r.nh;
      req_old_low     = r.ol;
      req_old_high    = r.oh;
      req_final_block = r.fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      n_blocks++;
      if (r.fin) n_intervals++;
      encode_block(r.nl, r.nh, r.ol, r.oh, r.fin, got);
      if (r.typed) begin
         got.delete();
         for (int j = 0; j < r.n_typed; j++)
            got.push_back('{r.t_kind[2-j], r.t_val[2-j], 1'(j == r.n_typed - 1)});
      end
      foreach (got[j]) pending_words.push_back(got[j]);
   endtask

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         n_words++;
         if (rsp_word_kind == ide_pkg::KIND_START) n_runs++;
         if (pending_words.size() == 0) begin
            $error("word with nothing expected: word_kind %0d, word_value 0x%08h",
                   rsp_word_kind, rsp_word_value);
            n_fail++;
         end else begin
            head = pending_words.pop_front();
            if (rsp_word_kind !== head.kind) begin
               $error("word_kind: expected %0d, got %0d", head.kind, rsp_word_kind);
               n_fail++;
            end
            if (rsp_word_value !== head.value) begin
               $error("word_value: expected 0x%08h, got 0x%08h", head.value, rsp_word_value);
               n_fail++;
            end
            if (rsp_item_last !== head.last) begin
               $error("item_last: expected %0b, got %0b", head.last, rsp_item_last);
               n_fail++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles++;
      end
   end

   initial begin
      blk_row_type dir_rows [$];
      blk_row_type r;
      int          sent;
      int          len;
      int          quiet;
      logic [ide_pkg::CSR_DATA_W-1:0] start_val;

      // after reset: window 32, start block 0
      dir_rows.push_back(blk_typed('0, '0, '0, '0, 1'b1, 1,
                                   {ide_pkg::KIND_TOTAL, ide_pkg::KIND_START,
                                    ide_pkg::KIND_START}, '0));
      dir_rows.push_back(blk_typed('1, '1, '1, '1, 1'b0, 0, '0, '0));
      dir_rows.push_back(blk_typed(HALF_A, HALF_A, HALF_A, HALF_A, 1'b1, 1,
                                   {ide_pkg::KIND_TOTAL, ide_pkg::KIND_START,
                                    ide_pkg::KIND_START}, '0));
      // only the high half differs: run starts at word 2
      dir_rows.push_back(blk_typed('0, 64'hFFFF_FFFF_0000_0001, '0, '0, 1'b0, 3,
                                   {ide_pkg::KIND_START, ide_pkg::KIND_DATA,
                                    ide_pkg::KIND_DATA},
                                   {32'd2, 32'd1, 32'hFFFF_FFFF}));
      dir_rows.push_back(blk_typed('0, '0, '0, '0, 1'b1, 2,
                                   {ide_pkg::KIND_END, ide_pkg::KIND_TOTAL,
                                    ide_pkg::KIND_START},
                                   {32'd4, 32'd4, 32'd0}));
      // run opened on the final block
      dir_rows.push_back(blk('1, '0, '0, '0, 1'b1));
      // held words flushed by later changes
      dir_rows.push_back(blk('1, '1, '0, '0, 1'b0));
      dir_rows.push_back(blk(HALF_A, HALF_B, HALF_A, HALF_B, 1'b0));
      dir_rows.push_back(blk(HALF_B, HALF_A, HALF_A, HALF_A, 1'b0));
      dir_rows.push_back(blk(HALF_A, HALF_B, HALF_A, HALF_A, 1'b0));
      dir_rows.push_back(blk(HALF_A, HALF_A, HALF_A, HALF_A, 1'b0));
      // window lowered while a run is open
      dir_rows.push_back(cfg_row(ROW_WINDOW, 30'd0));
      dir_rows.push_back(blk(HALF_B, HALF_B, HALF_B, HALF_B, 1'b0));
      dir_rows.push_back(blk(HALF_A, HALF_B, HALF_B, HALF_B, 1'b0));
      dir_rows.push_back(blk('0, '0, HALF_B, '0, 1'b0));
      dir_rows.push_back(blk('0, '0, '0, '0, 1'b1));
      // window above the maximum, positions wrapping past 2^32
      dir_rows.push_back(cfg_row(ROW_WINDOW, 30'd63));
      dir_rows.push_back(cfg_row(ROW_START, 30'h3FFF_FFFF));
      dir_rows.push_back(blk_typed(HALF_A, '0, HALF_A, 64'd1, 1'b0, 3,
                                   {ide_pkg::KIND_START, ide_pkg::KIND_DATA,
                                    ide_pkg::KIND_DATA},
                                   {32'hFFFF_FFFE, 32'd0, 32'd0}));
      dir_rows.push_back(blk_typed('0, '0, '0, '0, 1'b1, 2,
                                   {ide_pkg::KIND_END, ide_pkg::KIND_TOTAL,
                                    ide_pkg::KIND_START},
                                   {32'd0, 32'd4, 32'd0}));
      dir_rows.push_back(blk(HALF_B, HALF_A, '0, '0, 1'b0));
      dir_rows.push_back(blk_typed(HALF_A, HALF_A, HALF_A, HALF_A, 1'b1, 2,
                                   {ide_pkg::KIND_END, ide_pkg::KIND_TOTAL,
                                    ide_pkg::KIND_START},
                                   {32'd0, 32'd6, 32'd0}));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) begin
         case (dir_rows[i].op)
            ROW_WINDOW: csr_write(ide_pkg::CSR_WINDOW,
                                  dir_rows[i].nl[ide_pkg::CSR_DATA_W-1:0]);
            ROW_START:  csr_write(ide_pkg::CSR_START,
                                  dir_rows[i].nl[ide_pkg::CSR_DATA_W-1:0]);
            default:    send_block(dir_rows[i]);
         endcase
      end

      for (int p = 0; p < N_PHASES; p++) begin
         start_val = (p == N_PHASES - 1) ?
                     ide_pkg::CSR_DATA_W'($urandom_range(30'h3FFF_FFFF, 0)) :
                     PHASE_START[p];
         csr_write(ide_pkg::CSR_WINDOW, PHASE_WIN[p]);
         csr_write(ide_pkg::CSR_START, start_val);
         idle_pct  = IDLE_PCT[p % 4];
         stall_pct = STALL_PCT[p % 4];
         sent      = 0;
         while (sent < PHASE_BLOCKS) begin
            // long intervals with mostly unchanged blocks reach the wide windows
            len   = $urandom_range(1, (p == 2) ? 40 : 16);
            quiet = $urandom_range(30, 95);
            if ($urandom_range(99) < 5) wait_idle();
            for (int b = 0; b < len; b++) begin
               r.op    = ROW_BLOCK;
               r       = blk(rand_half(), rand_half(), '0, '0, 1'b0);
               r.ol    = r.nl;
               r.oh    = r.nh;
               r.fin   = (b == len - 1);
               if ($urandom_range(99) >= quiet) begin
                  case ($urandom_range(2))
                     0:       r.ol = flip_half(r.nl);
                     1:       r.oh = flip_half(r.nh);
                     default: begin
                        r.ol = flip_half(r.nl);
                        r.oh = flip_half(r.nh);
                     end
                  endcase
               end
               send_block(r);
               sent++;
            end
         end
      end

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d blocks in %0d intervals, %0d result words, %0d runs",
               n_blocks, n_intervals, n_words, n_runs);
      $display("windows 0 to 63 incl. clamping, start blocks 0 to 2^30-1, four timing mixes");
      if (n_fail == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[files.f]
hdl/ide_pkg.sv
hdl/ide_ram.sv
hdl/interval_diff_encoder.sv
verif/interval_diff_encoder_tb.sv
